// ----- hdl/csm_pkg.sv -----
// Package for the collinear stitch merger: register indexes, register reset
// values and the status bundle of the shared distance unit. No dependencies.
`default_nettype none

package csm_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERROR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_CODE = 2'd2;

  // Register reset values (0.1 mm and 3.6 mm in 0.01 mm units)
  localparam logic [15:0] MAX_ERROR_RST   = 16'd10;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd360;
  localparam logic [7:0]  NORMAL_CODE_RST = 8'd0;

  localparam int unsigned KIND_W = 8;

  // Status of the distance unit as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

`default_nettype wire

// ----- hdl/csm_dist.sv -----
// Shared distance unit: truncated sqrt(dx*dx + dy*dy) between two points.
// One multiplier used twice, then a digit-by-digit square root, one bit a cycle.
// Depends on csm_pkg.
`default_nettype none

module csm_dist #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [COORD_BITS-1:0]  ax_i,
  input  wire logic signed [COORD_BITS-1:0]  ay_i,
  input  wire logic signed [COORD_BITS-1:0]  bx_i,
  input  wire logic signed [COORD_BITS-1:0]  by_i,
  output csm_pkg::root_stat_t                stat_o,
  output logic [COORD_BITS:0]                root_o
);

  localparam int unsigned RT_W  = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned RAD_W = 2 * RT_W;
  localparam int unsigned REM_W = RT_W + 2;
  localparam int unsigned CNT_W = $clog2(RT_W);

  typedef enum logic [1:0] {U_IDLE, U_SQX, U_SQY, U_ROOT} ustate_e;

  ustate_e                 state_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic [SQ_W-1:0]         acc_q;
  logic [RAD_W-1:0]        rad_q;
  logic [REM_W-1:0]        rem_q;
  logic [RT_W-1:0]         root_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;

  logic signed [COORD_BITS:0] sdx, sdy;
  logic [COORD_BITS:0]        mdx, mdy;
  logic [COORD_BITS-1:0]      mul_a;
  logic [SQ_W-1:0]            prod;
  logic [SQ_W:0]              sq_sum;
  logic [REM_W-1:0]           rem_sh, trial;
  logic                       take;

  // Absolute coordinate differences
  always_comb begin
    sdx = $signed({ax_i[COORD_BITS-1], ax_i}) - $signed({bx_i[COORD_BITS-1], bx_i});
    sdy = $signed({ay_i[COORD_BITS-1], ay_i}) - $signed({by_i[COORD_BITS-1], by_i});
    mdx = sdx[COORD_BITS] ? (~sdx + 1'b1) : sdx;
    mdy = sdy[COORD_BITS] ? (~sdy + 1'b1) : sdy;
  end

  // Shared squarer
  assign mul_a  = (state_q == U_SQX) ? dx_q : dy_q;
  assign prod   = mul_a * mul_a;
  assign sq_sum = {1'b0, acc_q} + {1'b0, prod};

  // One root digit: bring down two radicand bits, try (4*root + 1)
  assign rem_sh = {rem_q[RT_W-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      dx_q    <= '0;
      dy_q    <= '0;
      acc_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      // flag the cycle after the last root digit
      done_q <= (state_q == U_ROOT) && (cnt_q == '0);
      case (state_q)
        U_IDLE: begin
          if (start_i) begin
            dx_q    <= mdx[COORD_BITS-1:0];
            dy_q    <= mdy[COORD_BITS-1:0];
            state_q <= U_SQX;
          end
        end
        U_SQX: begin
          acc_q   <= prod;
          state_q <= U_SQY;
        end
        U_SQY: begin
          rad_q   <= {1'b0, sq_sum};
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= CNT_W'(RT_W - 1);
          state_q <= U_ROOT;
        end
        U_ROOT: begin
          rad_q  <= rad_q << 2;
          rem_q  <= take ? (rem_sh - trial) : rem_sh;
          root_q <= {root_q[RT_W-2:0], take};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= U_IDLE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != U_IDLE);
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

// ----- hdl/collinear_stitch_merger.sv -----
// Collinear stitch merger: drops a held stitch point when it lies close enough
// to the line from the last kept point to the next one. Depends on csm_pkg, csm_dist.
//
// One point is taken at a time; in_stall_o stays high until its work is done.
// A point runs the collinearity test only when the anchor, the pending point
// and it all carry the normal kind code. A point that needs no test either
// only becomes pending, is emitted at once, forces the held point out, or
// forces it out and is then emitted as the final point. A point that runs the
// full test uses the shared distance unit up to three times in turn; each use
// starts the unit, squares dx and dy, forms the root digits and hands back the
// result. The test stops after the first distance when it already exceeds
// max_length, and the held point is then kept. Results leave through a
// one-beat output register; a point that emits waits for as long as the
// previous beat sits stalled there.
`default_nettype none

module collinear_stitch_merger #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [csm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [csm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // point input
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]        point_x_i,
  input  wire logic signed [COORD_BITS-1:0]        point_y_i,
  input  wire logic [csm_pkg::KIND_W-1:0]          stitch_kind_i,
  input  wire logic                                final_point_i,
  // kept point output
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [COORD_BITS-1:0]             out_x_o,
  output logic signed [COORD_BITS-1:0]             out_y_o,
  output logic [csm_pkg::KIND_W-1:0]               out_kind_o,
  output logic                                     out_last_o
);

  localparam int unsigned RT_W  = COORD_BITS + 1;
  localparam int unsigned SUM_W = (RT_W + 1 > 18) ? RT_W + 1 : 18;
  localparam int unsigned CMP_W = (RT_W > 16) ? RT_W : 16;

  typedef enum logic [2:0] {
    S_IDLE, S_D13, S_D12, S_D23, S_KEEP, S_TAIL, S_LAST
  } state_e;

  typedef enum logic [1:0] {HELD_NONE, HELD_ANCHOR, HELD_BOTH, HELD_SPARE} held_e;

  state_e state_q;
  held_e  held_q;

  logic [15:0]                  max_err_q, max_len_q;
  logic [csm_pkg::KIND_W-1:0]   normal_q;

  logic signed [COORD_BITS-1:0] anc_x_q, anc_y_q, pend_x_q, pend_y_q, new_x_q, new_y_q;
  logic [csm_pkg::KIND_W-1:0]   anc_kind_q, pend_kind_q, new_kind_q;
  logic                         new_fin_q;
  logic [RT_W-1:0]              d13_q, d12_q;
  logic                         start_q;

  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [csm_pkg::KIND_W-1:0]   out_kind_q;
  logic                         out_last_q, out_valid_q;

  csm_pkg::root_stat_t          root_stat;
  logic [RT_W-1:0]              root;
  logic signed [COORD_BITS-1:0] ua_x, ua_y, ub_x, ub_y;

  logic in_acc, slot_free, all_normal, too_long, dev_ok;
  logic start_d, out_load;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign all_normal = (anc_kind_q == normal_q) && (pend_kind_q == normal_q)
                      && (stitch_kind_i == normal_q);
  assign too_long   = CMP_W'(root) > CMP_W'(max_len_q);
  assign dev_ok     = (SUM_W'(d12_q) + SUM_W'(root))
                      <= (SUM_W'(d13_q) + SUM_W'({max_err_q, 1'b0}));

  // Kick the distance unit for the next test phase
  assign start_d = ((state_q == S_IDLE) && in_acc && (held_q != HELD_NONE)
                    && (held_q != HELD_ANCHOR) && all_normal)
                   || ((state_q == S_D13) && root_stat.done && !too_long)
                   || ((state_q == S_D12) && root_stat.done);

  // Load a new output beat when a point is emitted into a free slot
  assign out_load = ((state_q == S_KEEP) || (state_q == S_LAST)) && slot_free;

  // Pick the point pair for the distance unit by test phase
  always_comb begin
    ua_x = anc_x_q;  ua_y = anc_y_q;
    ub_x = new_x_q;  ub_y = new_y_q;
    case (state_q)
      S_D12: begin
        ub_x = pend_x_q; ub_y = pend_y_q;
      end
      S_D23: begin
        ua_x = pend_x_q; ua_y = pend_y_q;
      end
      default: ;
    endcase
  end

  csm_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .ax_i    (ua_x),
    .ay_i    (ua_y),
    .bx_i    (ub_x),
    .by_i    (ub_y),
    .stat_o  (root_stat),
    .root_o  (root)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_err_q <= csm_pkg::MAX_ERROR_RST;
      max_len_q <= csm_pkg::MAX_LENGTH_RST;
      normal_q  <= csm_pkg::NORMAL_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csm_pkg::CFG_MAX_ERROR:   max_err_q <= cfg_wdata_i;
        csm_pkg::CFG_MAX_LENGTH:  max_len_q <= cfg_wdata_i;
        csm_pkg::CFG_NORMAL_CODE: normal_q  <= cfg_wdata_i[csm_pkg::KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, held points and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= HELD_NONE;
      anc_x_q     <= '0;
      anc_y_q     <= '0;
      anc_kind_q  <= '0;
      pend_x_q    <= '0;
      pend_y_q    <= '0;
      pend_kind_q <= '0;
      new_x_q     <= '0;
      new_y_q     <= '0;
      new_kind_q  <= '0;
      new_fin_q   <= 1'b0;
      d13_q       <= '0;
      d12_q       <= '0;
      start_q     <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_kind_q  <= '0;
      out_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= start_d;
      // hold the output beat while stalled, release it once taken
      out_valid_q <= out_load || (out_valid_q && out_stall_i);

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            new_x_q    <= point_x_i;
            new_y_q    <= point_y_i;
            new_kind_q <= stitch_kind_i;
            new_fin_q  <= final_point_i;
            case (held_q)
              HELD_NONE: begin
                // first point: emit, and it becomes the anchor unless it is final
                if (!final_point_i) begin
                  anc_x_q    <= point_x_i;
                  anc_y_q    <= point_y_i;
                  anc_kind_q <= stitch_kind_i;
                  held_q     <= HELD_ANCHOR;
                end
                state_q <= S_LAST;
              end
              HELD_ANCHOR: begin
                if (final_point_i) begin
                  held_q  <= HELD_NONE;
                  state_q <= S_LAST;
                end else begin
                  pend_x_q    <= point_x_i;
                  pend_y_q    <= point_y_i;
                  pend_kind_q <= stitch_kind_i;
                  held_q      <= HELD_BOTH;
                end
              end
              default: begin
                if (all_normal) begin
                  state_q <= S_D13;
                end else begin
                  state_q <= S_KEEP;
                end
              end
            endcase
          end
        end
        S_D13: begin
          if (root_stat.done) begin
            if (too_long) begin
              state_q <= S_KEEP;
            end else begin
              d13_q   <= root;
              state_q <= S_D12;
            end
          end
        end
        S_D12: begin
          if (root_stat.done) begin
            d12_q   <= root;
            state_q <= S_D23;
          end
        end
        S_D23: begin
          if (root_stat.done) begin
            state_q <= dev_ok ? S_TAIL : S_KEEP;
          end
        end
        S_KEEP: begin
          // emit the pending point, it becomes the anchor
          if (slot_free) begin
            out_x_q     <= pend_x_q;
            out_y_q     <= pend_y_q;
            out_kind_q  <= pend_kind_q;
            out_last_q  <= 1'b0;
            anc_x_q     <= pend_x_q;
            anc_y_q     <= pend_y_q;
            anc_kind_q  <= pend_kind_q;
            state_q     <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (new_fin_q) begin
            held_q  <= HELD_NONE;
            state_q <= S_LAST;
          end else begin
            pend_x_q    <= new_x_q;
            pend_y_q    <= new_y_q;
            pend_kind_q <= new_kind_q;
            held_q      <= HELD_BOTH;
            state_q     <= S_IDLE;
          end
        end
        S_LAST: begin
          // emit the new point
          if (slot_free) begin
            out_x_q     <= new_x_q;
            out_y_q     <= new_y_q;
            out_kind_q  <= new_kind_q;
            out_last_q  <= new_fin_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  // A distance result only arrives while a test phase waits for it
  a_done_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_stat.done |-> (state_q == S_D13 || state_q == S_D12 || state_q == S_D23))
    else $error("distance result outside a test phase");

  // Never start the distance unit while it is still working
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> !root_stat.busy)
    else $error("distance unit started while busy");

  // The test only runs with an anchor and a pending point held
  a_test_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D13 || state_q == S_D12 || state_q == S_D23) |-> held_q == HELD_BOTH)
    else $error("collinearity test without a pending point");

  // Emitting a kept point never overwrites a beat still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && (state_q == S_KEEP || state_q == S_LAST))
    |=> out_valid_q && $stable(out_x_q) && $stable(out_last_q))
    else $error("output beat overwritten");

endmodule

`default_nettype wire

// ----- verif/collinear_stitch_merger_test.sv -----
// Self-checking testbench for collinear_stitch_merger: stitch polylines with random
// idle and stall, results compared against an in-bench merge predictor.
// Depends on csm_pkg and the collinear_stitch_merger RTL.
`default_nettype none

module collinear_stitch_merger_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS     = 16;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned SETTLE_CYCLES  = 120;
  localparam int unsigned HOLD_OFF_SPAN  = 400;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]    x;
    logic signed [COORD_BITS-1:0]    y;
    logic [csm_pkg::KIND_W-1:0]      kind;
    logic                            last;
  } stitch_t;

  typedef enum logic [1:0] {HELD_NONE, HELD_ANCHOR, HELD_BOTH} held_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                                cfg_we    = 1'b0;
  logic [csm_pkg::CFG_IDX_W-1:0]       cfg_idx   = csm_pkg::CFG_MAX_ERROR;
  logic [csm_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                                pt_valid  = 1'b0;
  logic signed [COORD_BITS-1:0]        pt_x      = '0;
  logic signed [COORD_BITS-1:0]        pt_y      = '0;
  logic [csm_pkg::KIND_W-1:0]          pt_kind   = '0;
  logic                                pt_last   = 1'b0;
  logic                                out_stall = 1'b0;
  wire logic                           in_stall;
  wire logic                           out_valid;
  wire logic signed [COORD_BITS-1:0]   out_x;
  wire logic signed [COORD_BITS-1:0]   out_y;
  wire logic [csm_pkg::KIND_W-1:0]     out_kind;
  wire logic                           out_last;

  // Stimulus feed, expected kept points and bookkeeping
  stitch_t     stitch_feed[$];
  stitch_t     kept_due[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left  = 0;
  logic        hold_off_go    = 1'b0;

  // Predictor copy of the registers and the merge state
  longint      lim_error  = csm_pkg::MAX_ERROR_RST;
  longint      lim_length = csm_pkg::MAX_LENGTH_RST;
  logic [csm_pkg::KIND_W-1:0] norm_code = csm_pkg::NORMAL_CODE_RST;
  stitch_t     anchor_pt  = '0;
  stitch_t     held_pt    = '0;
  held_e       held_state = HELD_NONE;

  collinear_stitch_merger #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (pt_valid),
    .in_stall_o    (in_stall),
    .point_x_i     (pt_x),
    .point_y_i     (pt_y),
    .stitch_kind_i (pt_kind),
    .final_point_i (pt_last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_x_o       (out_x),
    .out_y_o       (out_y),
    .out_kind_o    (out_kind),
    .out_last_o    (out_last)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Truncated integer root of the squared distance between two points
  function automatic longint seg_len(input stitch_t a, input stitch_t b);
    longint            dx;
    longint            dy;
    longint unsigned   sq;
    longint unsigned   root;
    longint unsigned   cand;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    sq = longint'(dx * dx + dy * dy);
    root = 0;
    for (int b_pos = 20; b_pos >= 0; b_pos--) begin
      cand = root | (64'd1 << b_pos);
      if (cand * cand <= sq) root = cand;
    end
    return longint'(root);
  endfunction

  // Decide whether the held point lies close enough to the anchor-to-new line
  function automatic bit held_is_collinear(input stitch_t nxt);
    longint d13;
    longint d12;
    longint d23;
    if (anchor_pt.kind != norm_code || held_pt.kind != norm_code || nxt.kind != norm_code)
      return 1'b0;
    d13 = seg_len(anchor_pt, nxt);
    if (d13 > lim_length) return 1'b0;
    d12 = seg_len(anchor_pt, held_pt);
    d23 = seg_len(held_pt, nxt);
    return (d12 + d23 - d13) <= 2 * lim_error;
  endfunction

  // Advance the merge state by one accepted point and queue the kept points it frees
  function automatic void merge_point(input stitch_t nxt);
    stitch_t kept;
    if (held_state == HELD_NONE) begin
      kept_due.push_back(nxt);
      if (!nxt.last) begin
        anchor_pt  = nxt;
        held_state = HELD_ANCHOR;
      end
    end else begin
      if (held_state == HELD_BOTH && !held_is_collinear(nxt)) begin
        kept      = held_pt;
        kept.last = 1'b0;
        kept_due.push_back(kept);
        anchor_pt = held_pt;
      end
      if (nxt.last) begin
        kept_due.push_back(nxt);
        held_state = HELD_NONE;
      end else begin
        held_pt    = nxt;
        held_state = HELD_BOTH;
      end
    end
  endfunction

  // Driver: offer the next queued point, hold it while stalled
  always @(posedge clk_i) begin : drive_points
    stitch_t nxt;
    stitch_t cur;
    if (rst_ni) begin
      if (pt_valid && !in_stall) begin
        cur = '{x: pt_x, y: pt_y, kind: pt_kind, last: pt_last};
        merge_point(cur);
      end
      if (!pt_valid || !in_stall) begin
        if (stitch_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = stitch_feed.pop_front();
          pt_valid <= 1'b1;
          pt_x     <= nxt.x;
          pt_y     <= nxt.y;
          pt_kind  <= nxt.kind;
          pt_last  <= nxt.last;
        end else begin
          pt_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest expected point
  always @(posedge clk_i) begin : watch_kept
    stitch_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (kept_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat x=%0d y=%0d kind=%0d last=%0b",
                                    out_x, out_y, out_kind, out_last));
        end else begin
          want = kept_due.pop_front();
          if (out_x !== want.x)
            report_mismatch($sformatf("out_x %0d, want %0d", out_x, want.x));
          if (out_y !== want.y)
            report_mismatch($sformatf("out_y %0d, want %0d", out_y, want.y));
          if (out_kind !== want.kind)
            report_mismatch($sformatf("out_kind %0d, want %0d", out_kind, want.kind));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last));
        end
      end
      out_stall <= (hold_off_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_go) begin
      hold_off_left <= HOLD_OFF_SPAN;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [csm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      csm_pkg::CFG_MAX_ERROR:   lim_error  = data;
      csm_pkg::CFG_MAX_LENGTH:  lim_length = data;
      csm_pkg::CFG_NORMAL_CODE: norm_code  = data[csm_pkg::KIND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_point(input int x, input int y, input int kind, input bit last);
    stitch_t p;
    p.x    = x[COORD_BITS-1:0];
    p.y    = y[COORD_BITS-1:0];
    p.kind = kind[csm_pkg::KIND_W-1:0];
    p.last = last;
    stitch_feed.push_back(p);
  endtask

  // Fill the feed with polylines of random shape, plus some pure noise points
  task automatic queue_patterns(input int n_items);
    int count;
    int len;
    int px;
    int py;
    int sx;
    int sy;
    int span;
    int jit;
    int kind;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        add_point($urandom, $urandom, $urandom_range(0, 255), $urandom_range(0, 3) == 0);
        count++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 25);
        case ($urandom_range(0, 3))
          0: span = 2;
          1: span = 30;
          2: span = 150;
          default: span = 800;
        endcase
        jit = $urandom_range(0, 4);
        px  = $urandom_range(0, 60000) - 30000;
        py  = $urandom_range(0, 60000) - 30000;
        sx  = $urandom_range(0, 2 * span) - span;
        sy  = $urandom_range(0, 2 * span) - span;
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            sx = $urandom_range(0, 2 * span) - span;
            sy = $urandom_range(0, 2 * span) - span;
          end
          px += sx + $urandom_range(0, 2 * jit) - jit;
          py += sy + $urandom_range(0, 2 * jit) - jit;
          kind = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : norm_code;
          // most patterns close with a final point, some are left open
          add_point(px, py, kind, (k == len - 1) && ($urandom_range(0, 7) != 0));
          count++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (stitch_feed.size() != 0 || pt_valid || kept_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int n_items, input bit with_hold_off);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_patterns(n_items);
    if (with_hold_off) begin
      repeat (20) @(posedge clk_i);
      hold_off_go <= 1'b1;
      @(posedge clk_i);
      hold_off_go <= 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed points at reset register values
    add_point(0, 0, 0, 1'b1);              // final with nothing held
    add_point(-32768, -32768, 0, 1'b0);    // first point, extreme corner
    add_point(32767, 32767, 0, 1'b1);      // final with only an anchor held
    add_point(0, 0, 0, 1'b0);
    add_point(100, 0, 0, 1'b0);
    add_point(200, 0, 0, 1'b0);            // on the line, dropped
    add_point(300, 0, 0, 1'b0);            // dropped again
    add_point(400, 0, 0, 1'b0);            // merged stitch too long
    add_point(400, 100, 0, 1'b0);          // corner, deviation too large
    add_point(400, 200, 255, 1'b0);        // odd kind keeps the held point
    add_point(400, 300, 0, 1'b0);          // held point has odd kind
    add_point(32767, -32768, 0, 1'b0);     // widest distances
    add_point(-32768, 32767, 0, 1'b0);
    add_point(5, 5, 0, 1'b1);              // final with two held, held kept
    add_point(0, 0, 0, 1'b0);
    add_point(1, 1, 0, 1'b0);
    add_point(3, 3, 0, 1'b0);              // truncation makes the deviation negative
    add_point(4, 4, 0, 1'b1);              // final with two held, held dropped
    add_point(-1, -1, 0, 1'b0);
    add_point(-1, -1, 0, 1'b0);            // repeated point
    add_point(-1, -1, 0, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();

    run_phase(0, 0, 250, 1'b1);

    write_reg(csm_pkg::CFG_MAX_ERROR, 16'd0);
    write_reg(csm_pkg::CFG_MAX_LENGTH, 16'd0);
    run_phase(75, 0, 250, 1'b0);

    write_reg(csm_pkg::CFG_MAX_ERROR, 16'hFFFF);
    write_reg(csm_pkg::CFG_MAX_LENGTH, 16'hFFFF);
    write_reg(csm_pkg::CFG_NORMAL_CODE, 16'h00FF);
    run_phase(0, 75, 250, 1'b0);

    write_reg(csm_pkg::CFG_MAX_ERROR, 16'd3);
    write_reg(csm_pkg::CFG_MAX_LENGTH, 16'd1000);
    write_reg(csm_pkg::CFG_NORMAL_CODE, 16'h005A);
    run_phase(13, 13, 280, 1'b0);

    write_reg(csm_pkg::CFG_MAX_ERROR, 16'd40);
    write_reg(csm_pkg::CFG_MAX_LENGTH, 16'd500);
    write_reg(csm_pkg::CFG_NORMAL_CODE, 16'h0001);
    run_phase(75, 75, 280, 1'b0);

    write_reg(csm_pkg::CFG_MAX_ERROR, csm_pkg::MAX_ERROR_RST);
    write_reg(csm_pkg::CFG_MAX_LENGTH, csm_pkg::MAX_LENGTH_RST);
    write_reg(csm_pkg::CFG_NORMAL_CODE, {8'd0, csm_pkg::NORMAL_CODE_RST});
    run_phase(13, 13, 220, 1'b0);

    if (kept_due.size() != 0)
      report_mismatch($sformatf("%0d kept points never arrived", kept_due.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
